>>> rtl/core/rmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants of the running median tracker
// Sizes of the sorted cell row, operation and status codes, and the words
// passed between neighboring cells.
// ----------------------------------------------------------------------------
package rmt_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS   = $clog2(CAPACITY);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [IDX_BITS-1:0]          idx_type;

   // operation kind on the request word
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_ABSENT = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_REPORT = 1'b1
   } state_type;

   // broadcast to every cell for one update
   typedef struct packed {
      logic      ins_en;
      logic      del_en;
      value_type value;
   } op_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic      gt;     // new value sorts before this cell's entry (or cell free)
      logic      ge;     // this cell's entry is >= new value (or cell free)
      value_type value;
   } link_type;

endpackage
`default_nettype wire

>>> rtl/core/rmt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_cell: one slot of the sorted row
// Holds one value, compares it to the broadcast value and shifts in from
// the left (insert) or the right (remove).
// ----------------------------------------------------------------------------
module rmt_cell (
   input  wire logic               clock,
   input  wire rmt_pkg::op_type    op,
   input  wire logic               found,
   input  wire logic               live,
   input  wire rmt_pkg::link_type  left,
   input  wire rmt_pkg::value_type right_value,
   output rmt_pkg::link_type       link,
   output logic                    hit
);

   rmt_pkg::value_type value_ff;
   rmt_pkg::value_type value_in;
   logic               gt;
   logic               ge;

   always_comb begin
      gt  = !live || (op.value < value_ff);
      ge  = !live || !(value_ff < op.value);
      // first live entry not below the value, and equal to it
      hit = live && ge && !left.ge && (value_ff == op.value);
   end

   assign link = '{gt: gt, ge: ge, value: value_ff};

   always_comb begin
      value_in = value_ff;
      if (op.ins_en && gt) begin
         value_in = left.gt ? left.value : op.value;
      end else if (op.del_en && found && live && ge) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/rmt_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmt_chain: row of sorted cells
// Wires the cells to their neighbors, collects the match for removal and
// selects the entry at the median position.
// ----------------------------------------------------------------------------
module rmt_chain (
   input  wire logic               clock,
   input  wire rmt_pkg::op_type    op,
   input  wire rmt_pkg::count_type count,
   input  wire rmt_pkg::idx_type   med_idx,
   output logic                    found,
   output rmt_pkg::value_type      med_value
);

   rmt_pkg::link_type                    links [rmt_pkg::CAPACITY];
   rmt_pkg::value_type                   vals  [rmt_pkg::CAPACITY];
   logic [rmt_pkg::CAPACITY-1:0]         hits;

   for (genvar i = 0; i < rmt_pkg::CAPACITY; i++) begin : g_cell
      rmt_pkg::link_type  left;
      rmt_pkg::value_type right_value;
      logic               live;

      assign live = count > rmt_pkg::COUNT_BITS'(i);
      assign vals[i] = links[i].value;

      if (i == 0) begin : g_head
         assign left = '{gt: 1'b0, ge: 1'b0, value: '0};
      end else begin : g_body
         assign left = links[i-1];
      end

      if (i == rmt_pkg::CAPACITY - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = links[i+1].value;
      end

      rmt_cell u_cell (
         .clock       (clock),
         .op          (op),
         .found       (found),
         .live        (live),
         .left        (left),
         .right_value (right_value),
         .link        (links[i]),
         .hit         (hits[i])
      );
   end

   assign found     = |hits;
   assign med_value = vals[med_idx];

endmodule
`default_nettype wire

>>> rtl/core/running_median_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_tracker: lower median of a bounded sorted multiset
// Sorted row of cells with insert/remove and median report.
// ----------------------------------------------------------------------------
// Each request word inserts (kind 0) or removes one copy of (kind 1) a signed
// value; one response word follows per request with the lower median (entry
// (count-1)/2 of the ascending store), the count, an empty flag and a status
// (ok, insert refused because full, removed value absent). Median is 0 when
// empty. Values live in a row of CAPACITY cells kept in ascending order; every
// cell compares its entry to the request value in parallel and the row shifts
// one place right (insert) or left (remove). An item passes through the row
// update, then the median select into the response register. The next
// request is taken while a response still waits for rsp_ready; a further
// one waits until that response slot frees up.
// Equal values: an insert lands after existing copies.
// ----------------------------------------------------------------------------
module running_median_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic signed [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_median,
   output logic [6:0]       rsp_count,
   output logic             rsp_empty_res,
   output logic [1:0]       rsp_status
);

   rmt_pkg::state_type  state_ff, state_in;
   rmt_pkg::count_type  count_ff, count_in;
   rmt_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rmt_pkg::value_type  median_ff, median_in;
   rmt_pkg::count_type  rcount_ff, rcount_in;
   logic                empty_ff, empty_in;
   rmt_pkg::status_type rstatus_ff, rstatus_in;

   rmt_pkg::op_type     op;
   rmt_pkg::idx_type    med_idx;
   rmt_pkg::value_type  med_value;
   rmt_pkg::count_type  count_dec;
   logic                found;
   logic                accept;
   logic                full;
   logic                load_rsp;

   // request decode
   assign accept = req_valid && req_ready;
   assign full   = count_ff == rmt_pkg::COUNT_BITS'(rmt_pkg::CAPACITY);

   always_comb begin
      op.ins_en = accept && (req_kind == rmt_pkg::KIND_INSERT) && !full;
      op.del_en = accept && (req_kind == rmt_pkg::KIND_REMOVE);
      op.value  = req_value;
   end

   // median position (count-1)/2, only used when count is nonzero
   assign count_dec = count_ff - rmt_pkg::COUNT_BITS'(1);
   assign med_idx   = rmt_pkg::IDX_BITS'(count_dec >> 1);

   rmt_chain u_chain (
      .clock     (clock),
      .op        (op),
      .count     (count_ff),
      .med_idx   (med_idx),
      .found     (found),
      .med_value (med_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmt_pkg::S_IDLE: begin
            if (accept) state_in = rmt_pkg::S_REPORT;
         end
         rmt_pkg::S_REPORT: begin
            if (load_rsp) state_in = rmt_pkg::S_IDLE;
         end
         default: state_in = rmt_pkg::S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         rmt_pkg::S_IDLE:   req_ready = 1'b1;
         rmt_pkg::S_REPORT: load_rsp  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   // count and pending status
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (op.ins_en) begin
         count_in  = count_ff + rmt_pkg::COUNT_BITS'(1);
         status_in = rmt_pkg::STAT_OK;
      end else if (accept && req_kind == rmt_pkg::KIND_INSERT) begin
         status_in = rmt_pkg::STAT_FULL;
      end else if (op.del_en && found) begin
         count_in  = count_dec;
         status_in = rmt_pkg::STAT_OK;
      end else if (op.del_en) begin
         status_in = rmt_pkg::STAT_ABSENT;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      rcount_in    = rcount_ff;
      empty_in     = empty_ff;
      rstatus_in   = rstatus_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         empty_in     = count_ff == '0;
         median_in    = (count_ff == '0) ? '0 : med_value;
         rcount_in    = count_ff;
         rstatus_in   = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      median_ff  <= median_in;
      rcount_ff  <= rcount_in;
      empty_ff   <= empty_in;
      rstatus_ff <= rstatus_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median    = 32'(median_ff);
   assign rsp_count     = 7'(rcount_ff);
   assign rsp_empty_res = empty_ff;
   assign rsp_status    = rstatus_ff;

   // ---------------------------------------------------------------- checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rmt_pkg::COUNT_BITS'(rmt_pkg::CAPACITY))
      else $error("held count above capacity");

   a_accept_report: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rmt_pkg::S_REPORT)
      else $error("accepted word not followed by report state");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && full && req_kind == rmt_pkg::KIND_INSERT) |=>
         (count_ff == $past(count_ff)) && (status_ff == rmt_pkg::STAT_FULL))
      else $error("refused insert changed count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_count == 7'd0)))
      else $error("empty flag disagrees with count");

   a_absent_holds: assert property (@(posedge clock) disable iff (reset)
      (op.del_en && !found) |=> count_ff == $past(count_ff))
      else $error("absent remove changed count");

endmodule
`default_nettype wire

>>> test/running_median_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_tracker_tb: self-checking bench for the running median tracker
// Sends insert and remove words, tracks a sorted copy of the store next to the
// block, and checks the median, count, empty flag and status of every response
// word in order, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module running_median_tracker_tb;

   // one expected response word
   typedef struct {
      rmt_pkg::value_type  median;
      logic [6:0]          count;
      logic                is_empty;
      rmt_pkg::status_type status;
   } median_word_type;

   localparam rmt_pkg::value_type VAL_MAX = 32'sh7FFF_FFFF;
   localparam rmt_pkg::value_type VAL_MIN = 32'sh8000_0000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind  = rmt_pkg::KIND_INSERT;
   rmt_pkg::value_type req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rmt_pkg::value_type rsp_median;
   logic [6:0]         rsp_count;
   logic               rsp_empty_res;
   logic [1:0]         rsp_status;

   // sorted shadow of the block's store; only entries below shadow_count are live
   rmt_pkg::value_type shadow_row [rmt_pkg::CAPACITY];
   int                 shadow_count = 0;
   median_word_type    pending_medians [$];

   int errors     = 0;
   int n_insert   = 0;
   int n_remove   = 0;
   int n_full     = 0;
   int n_absent   = 0;
   int peak_count = 0;
   bit gaps_on    = 1'b1;   // sender idles in bursts
   bit stalls_on  = 1'b1;   // receiver stalls in bursts

   running_median_tracker u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_median    (rsp_median),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop; the slowest legal run is well under a tenth of this.
   initial begin
      #2_000_000;
      $display("timeout with %0d response words outstanding", pending_medians.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Apply one word to the shadow store and work out the response it gives.
   // Inserts go after equal copies; removes take the first equal copy.
   function automatic median_word_type next_median_word(input logic kind,
                                                        input rmt_pkg::value_type v);
      median_word_type w;
      int pos;
      w.status = rmt_pkg::STAT_OK;
      pos = 0;
      if (kind == rmt_pkg::KIND_INSERT) begin
         if (shadow_count >= rmt_pkg::CAPACITY) begin
            w.status = rmt_pkg::STAT_FULL;
         end else begin
            while (pos < shadow_count && !(v < shadow_row[pos])) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_row[i] = shadow_row[i-1];
            shadow_row[pos] = v;
            shadow_count++;
         end
      end else begin
         while (pos < shadow_count && shadow_row[pos] != v) pos++;
         if (pos >= shadow_count) begin
            w.status = rmt_pkg::STAT_ABSENT;
         end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_row[i] = shadow_row[i+1];
            shadow_count--;
         end
      end
      // lower median: entry (count-1)/2, zero when nothing is held
      w.median   = (shadow_count == 0) ? rmt_pkg::value_type'(0)
                                       : shadow_row[(shadow_count - 1) / 2];
      w.count    = 7'(shadow_count);
      w.is_empty = (shadow_count == 0);
      return w;
   endfunction

   // Value mix: narrow band for duplicates, full-width random, and values near
   // both ends of the signed range.
   function automatic rmt_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return rmt_pkg::value_type'($urandom_range(0, 8)) - 4;
         4, 5, 6, 7: return rmt_pkg::value_type'($urandom);
         default:
            return $urandom_range(0, 1)
                      ? VAL_MAX - rmt_pkg::value_type'($urandom_range(0, 3))
                      : VAL_MIN + rmt_pkg::value_type'($urandom_range(0, 3));
      endcase
   endfunction

   // Append one prediction at the tail of the expected queue.
   task automatic enqueue_expected(input median_word_type w);
      pending_medians.insert(pending_medians.size(), w);
   endtask

   // Send one request word. Valid only drops when an idle burst is taken, so
   // back-to-back words keep it high with one assignment per edge.
   task automatic send_word(input logic kind, input rmt_pkg::value_type v);
      median_word_type w;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: predict now so the queue stays in issue order
      w = next_median_word(kind, v);
      enqueue_expected(w);
      if (kind == rmt_pkg::KIND_INSERT) n_insert++;
      else                              n_remove++;
      if (w.status == rmt_pkg::STAT_FULL)   n_full++;
      if (w.status == rmt_pkg::STAT_ABSENT) n_absent++;
      if (shadow_count > peak_count) peak_count = shadow_count;
   endtask

   // Hold off the sender until every response word is back, then let the
   // pipe settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Extremes, duplicates, absent removes on an empty and non-empty store,
   // and walking back down to empty.
   task automatic test_directed();
      send_word(rmt_pkg::KIND_REMOVE, 0);              // remove from empty store
      send_word(rmt_pkg::KIND_INSERT, VAL_MAX);
      send_word(rmt_pkg::KIND_INSERT, VAL_MIN);
      send_word(rmt_pkg::KIND_INSERT, 0);
      send_word(rmt_pkg::KIND_INSERT, -1);
      send_word(rmt_pkg::KIND_INSERT, 0);              // equal copies
      send_word(rmt_pkg::KIND_INSERT, 0);
      send_word(rmt_pkg::KIND_REMOVE, 0);              // takes only one copy
      send_word(rmt_pkg::KIND_REMOVE, 5);              // absent, store not empty
      send_word(rmt_pkg::KIND_REMOVE, VAL_MAX);
      send_word(rmt_pkg::KIND_REMOVE, VAL_MIN);
      send_word(rmt_pkg::KIND_REMOVE, -1);
      send_word(rmt_pkg::KIND_REMOVE, 0);
      send_word(rmt_pkg::KIND_REMOVE, 0);              // back to empty
      send_word(rmt_pkg::KIND_REMOVE, 0);              // absent again once empty
      send_word(rmt_pkg::KIND_INSERT, 32'sh5555_5555);
      send_word(rmt_pkg::KIND_INSERT, 32'shAAAA_AAAA);
      send_word(rmt_pkg::KIND_INSERT, 32'sh5555_5555);
      send_word(rmt_pkg::KIND_REMOVE, 32'shAAAA_AAAA);
      send_word(rmt_pkg::KIND_REMOVE, 32'sh5555_5555);
      send_word(rmt_pkg::KIND_REMOVE, 32'sh5555_5555);
      wait_drained();
   endtask

   // Fill to capacity, knock on the full store, then empty it from random spots.
   task automatic test_full_store();
      while (shadow_count < rmt_pkg::CAPACITY) send_word(rmt_pkg::KIND_INSERT, pick_value());
      repeat (3) send_word(rmt_pkg::KIND_INSERT, pick_value());
      send_word(rmt_pkg::KIND_REMOVE, shadow_row[$urandom_range(0, rmt_pkg::CAPACITY - 1)]);
      send_word(rmt_pkg::KIND_INSERT, VAL_MIN);        // takes the freed slot
      send_word(rmt_pkg::KIND_INSERT, VAL_MAX);        // refused again
      while (shadow_count > 0)
         send_word(rmt_pkg::KIND_REMOVE, shadow_row[$urandom_range(0, shadow_count - 1)]);
      wait_drained();
   endtask

   // Mixed traffic; insert_pct steers the store toward full or empty.
   // Most removes target a held value so the store actually moves.
   task automatic test_random_walk(input int n_words, input int insert_pct);
      repeat (n_words) begin
         if ($urandom_range(0, 99) < insert_pct)
            send_word(rmt_pkg::KIND_INSERT, pick_value());
         else if (shadow_count > 0 && $urandom_range(0, 9) != 0)
            send_word(rmt_pkg::KIND_REMOVE, shadow_row[$urandom_range(0, shadow_count - 1)]);
         else
            send_word(rmt_pkg::KIND_REMOVE, pick_value());
      end
      wait_drained();
   endtask

   // Receiver: ready in runs, broken by random stall bursts.
   initial begin
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Response checker: every accepted word against the oldest prediction.
   always @(posedge clock) begin
      median_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, median %0d count %0d",
                     $time, rsp_median, rsp_count);
         end else begin
            w = pending_medians.pop_front();
            if (rsp_median !== w.median) begin
               errors++;
               $display("%0t: median expected %0d, got %0d", $time, w.median, rsp_median);
            end
            if (rsp_count !== w.count) begin
               errors++;
               $display("%0t: count expected %0d, got %0d", $time, w.count, rsp_count);
            end
            if (rsp_empty_res !== w.is_empty) begin
               errors++;
               $display("%0t: empty expected %0b, got %0b", $time, w.is_empty, rsp_empty_res);
            end
            if (rsp_status !== w.status) begin
               errors++;
               $display("%0t: status expected %0d, got %0d", $time, w.status, rsp_status);
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_store();
      test_random_walk(300, 70);   // pushes into the full store
      test_random_walk(300, 50);
      test_random_walk(300, 30);   // hovers near empty
      test_random_walk(300, 55);

      // closing stretch at full rate, no idle or stall
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_random_walk(150, 50);

      $display("sent %0d inserts and %0d removes: %0d refused as full, %0d absent removes",
               n_insert, n_remove, n_full, n_absent);
      $display("store held up to %0d of %0d values", peak_count, rmt_pkg::CAPACITY);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
